>>> design/tgl_pkg.sv
`default_nettype none
package tgl_pkg;

    localparam int GRID_XY     = 32;
    localparam int GRID_Z      = 16;
    localparam int SLOTS       = 4;
    localparam int SAMPLE_BITS = 24;

    localparam int XB = $clog2(GRID_XY);
    localparam int ZB = $clog2(GRID_Z);
    localparam int SB = $clog2(SLOTS);

    localparam int WORD_BITS  = 2 * SAMPLE_BITS;
    localparam int BANKS      = 8;
    localparam int BANK_DEPTH = SLOTS * GRID_Z * GRID_XY * GRID_XY / BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int CFG_BITS = 48;
    localparam int IDX_BITS = 3;
    localparam int FRAC_BITS = 16;

    // accept edge to strobe sample edge
    localparam int PIPE_LAT = 11;

    localparam logic [23:0] INV_STEP_RESET = 24'h010000;
    localparam logic signed [25:0] OUT_MAX = 26'sd8388607;
    localparam logic signed [25:0] OUT_MIN = -26'sd8388608;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_RADIUS_SQ    = 3'd0,
        CFG_INV_STEP_X   = 3'd1,
        CFG_INV_STEP_Y   = 3'd2,
        CFG_INV_STEP_Z   = 3'd3,
        CFG_COMPLEX_MASK = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic outside;
        logic clipped;
        logic zero_re;
        logic zero_im;
    } tgl_ctl_t;

    typedef struct packed {
        logic [7:0]  i0;
        logic [7:0]  i1;
        logic [15:0] frac;
        logic        clip;
    } axis_t;

    function automatic axis_t split_axis(logic [47:0] scaled, logic [8:0] limit);
        axis_t       r;
        logic [15:0] idx;
        logic [15:0] last;
        logic [16:0] nxt;
        idx    = scaled[47:32];
        last   = 16'(limit - 9'd1);
        r.frac = scaled[31:16];
        r.clip = 1'b0;
        if (idx > last)
        begin
            idx    = last;
            r.clip = 1'b1;
        end
        r.i0 = idx[7:0];
        nxt  = {1'b0, idx} + 17'd1;
        if (nxt > {1'b0, last})
        begin
            r.i1   = last[7:0];
            r.clip = 1'b1;
        end
        else
        begin
            r.i1 = nxt[7:0];
        end
        return r;
    endfunction

    function automatic logic signed [24:0] diff25(logic signed [23:0] a,
                                                  logic signed [23:0] b);
        return $signed({b[23], b}) - $signed({a[23], a});
    endfunction

    // a + round((b - a) * f / 65536), given p = (b - a) * f
    function automatic logic signed [25:0] lerp_sum(logic signed [23:0] a,
                                                    logic signed [41:0] p);
        logic signed [41:0] t;
        t = p + 42'sd32768;
        return $signed({{2{a[23]}}, a}) + $signed(t[41:16]);
    endfunction

    function automatic logic signed [23:0] sat24(logic signed [25:0] v);
        if (v > OUT_MAX)
            return 24'h7FFFFF;
        else if (v < OUT_MIN)
            return 24'h800000;
        else
            return v[23:0];
    endfunction

endpackage
`default_nettype wire

>>> design/tgl_ram.sv
`default_nettype none
module tgl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

>>> design/tgl_lerp_tree.sv
`default_nettype none
module tgl_lerp_tree (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tgl_pkg::tgl_ctl_t     in_ctl,
    input  wire logic signed [23:0]    corner [2][8],
    input  wire logic [15:0]           fx,
    input  wire logic [15:0]           fy,
    input  wire logic [15:0]           fz,
    output tgl_pkg::tgl_ctl_t          out_ctl,
    output logic signed [23:0]         out_re,
    output logic signed [23:0]         out_im
);
    import tgl_pkg::*;

    tgl_ctl_t ctl_reg [6];

    logic signed [23:0] a1_reg [2][4];
    logic signed [41:0] p1_reg [2][4];
    logic [15:0]        fy1_reg, fy2_reg;
    logic [15:0]        fz1_reg, fz2_reg, fz3_reg, fz4_reg;

    logic signed [23:0] a2_reg [2][2];
    logic signed [24:0] d2_reg [2][2];
    logic signed [23:0] a3_reg [2][2];
    logic signed [41:0] p3_reg [2][2];
    logic signed [23:0] a4_reg [2];
    logic signed [24:0] d4_reg [2];
    logic signed [23:0] a5_reg [2];
    logic signed [41:0] p5_reg [2];
    logic signed [23:0] out_reg [2];

    logic signed [25:0] r_next [2][4];
    logic signed [25:0] l_next [2][2];
    logic signed [25:0] v_next [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int m = 0; m < 4; m++)
                r_next[l][m] = lerp_sum(a1_reg[l][m], p1_reg[l][m]);
            for (int k = 0; k < 2; k++)
                l_next[l][k] = lerp_sum(a3_reg[l][k], p3_reg[l][k]);
            v_next[l] = lerp_sum(a5_reg[l], p5_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 6; s++)
                ctl_reg[s] <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
            for (int s = 1; s < 6; s++)
                ctl_reg[s] <= ctl_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        fy1_reg <= fy;
        fy2_reg <= fy1_reg;
        fz1_reg <= fz;
        fz2_reg <= fz1_reg;
        fz3_reg <= fz2_reg;
        fz4_reg <= fz3_reg;
        for (int l = 0; l < 2; l++)
        begin
            // m = {z, y}, x pairs are corners 2m and 2m+1
            for (int m = 0; m < 4; m++)
            begin
                a1_reg[l][m] <= corner[l][2*m];
                p1_reg[l][m] <= diff25(corner[l][2*m], corner[l][2*m+1])
                                * $signed({1'b0, fx});
            end
            for (int k = 0; k < 2; k++)
            begin
                a2_reg[l][k] <= r_next[l][2*k][23:0];
                d2_reg[l][k] <= diff25(r_next[l][2*k][23:0], r_next[l][2*k+1][23:0]);
                a3_reg[l][k] <= a2_reg[l][k];
                p3_reg[l][k] <= d2_reg[l][k] * $signed({1'b0, fy2_reg});
            end
            a4_reg[l] <= l_next[l][0][23:0];
            d4_reg[l] <= diff25(l_next[l][0][23:0], l_next[l][1][23:0]);
            a5_reg[l] <= a4_reg[l];
            p5_reg[l] <= d4_reg[l] * $signed({1'b0, fz4_reg});
        end
        out_reg[0] <= ctl_reg[4].zero_re ? 24'sd0 : sat24(v_next[0]);
        out_reg[1] <= ctl_reg[4].zero_im ? 24'sd0 : sat24(v_next[1]);
    end

    assign out_ctl = ctl_reg[5];
    assign out_re  = out_reg[0];
    assign out_im  = out_reg[1];
endmodule
`default_nettype wire

>>> design/trilinear_grid_lookup.sv
`default_nettype none
// channel   direction  transfer when       payload
// item      in         start && !busy     op, box_slot, load_*, pos_x/y/z
// result    out        done               value_re, value_im, outside, clipped
// config    in         cfg_we             cfg_index, cfg_data
//
// One item per cycle; busy is never raised.
// A query strobes done after stages 0-4 and the lerp tree; loads give no result.
// Grid words sit in 8 banks split by corner parity, so all corners read at once.
// Loads write at the same stage where queries read, keeping item order.
// rst_n clears valids and all config but inv steps; grid undefined until loaded.
module trilinear_grid_lookup (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [1:0]                    box_slot,
    input  wire logic [4:0]                    load_col,
    input  wire logic [4:0]                    load_row,
    input  wire logic [3:0]                    load_layer,
    input  wire logic signed [23:0]            load_re,
    input  wire logic signed [23:0]            load_im,
    input  wire logic signed [23:0]            pos_x,
    input  wire logic signed [23:0]            pos_y,
    input  wire logic signed [23:0]            pos_z,
    input  wire logic                          cfg_we,
    input  wire logic [tgl_pkg::IDX_BITS-1:0]  cfg_index,
    input  wire logic [tgl_pkg::CFG_BITS-1:0]  cfg_data,
    output logic                               done,
    output logic signed [23:0]                 value_re,
    output logic signed [23:0]                 value_im,
    output logic                               outside,
    output logic                               clipped
);
    import tgl_pkg::*;

    logic [47:0]      radius_sq_reg;
    logic [23:0]      inv_x_reg, inv_y_reg, inv_z_reg;
    logic [SLOTS-1:0] cmask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= '0;
            inv_x_reg     <= INV_STEP_RESET;
            inv_y_reg     <= INV_STEP_RESET;
            inv_z_reg     <= INV_STEP_RESET;
            cmask_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS_SQ:    radius_sq_reg <= cfg_data[47:0];
                CFG_INV_STEP_X:   inv_x_reg     <= cfg_data[23:0];
                CFG_INV_STEP_Y:   inv_y_reg     <= cfg_data[23:0];
                CFG_INV_STEP_Z:   inv_z_reg     <= cfg_data[23:0];
                CFG_COMPLEX_MASK: cmask_reg     <= cfg_data[SLOTS-1:0];
                default:          ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: input capture
    logic               s0_valid_reg, s0_op_reg;
    logic [1:0]         s0_slot_reg;
    logic [4:0]         s0_col_reg, s0_row_reg;
    logic [3:0]         s0_layer_reg;
    logic [47:0]        s0_word_reg;
    logic signed [23:0] s0_px_reg, s0_py_reg, s0_pz_reg;

    // stage 1: products
    logic               s1_valid_reg, s1_op_reg;
    logic [1:0]         s1_slot_reg;
    logic [4:0]         s1_col_reg, s1_row_reg;
    logic [3:0]         s1_layer_reg;
    logic [47:0]        s1_word_reg;
    logic [47:0]        s1_sqx_reg, s1_sqy_reg, s1_sqz_reg;
    logic [47:0]        s1_scx_reg, s1_scy_reg, s1_scz_reg;

    // stage 2: radius test, split, bank access
    logic               s2_valid_reg, s2_op_reg, s2_out_reg, s2_clip_reg, s2_cplx_reg;
    logic [1:0]         s2_slot_reg;
    logic [4:0]         s2_col_reg, s2_row_reg;
    logic [3:0]         s2_layer_reg;
    logic [47:0]        s2_word_reg;
    logic [XB-1:0]      s2_x0_reg, s2_x1_reg, s2_y0_reg, s2_y1_reg;
    logic [ZB-1:0]      s2_z0_reg, s2_z1_reg;
    logic [15:0]        s2_fx_reg, s2_fy_reg, s2_fz_reg;

    // stage 3: bank data out
    tgl_ctl_t           s3_ctl_reg;
    logic [5:0]         s3_par_reg;
    logic [15:0]        s3_fx_reg, s3_fy_reg, s3_fz_reg;

    // stage 4: corners
    tgl_ctl_t           s4_ctl_reg;
    logic signed [23:0] s4_corner_reg [2][8];
    logic [15:0]        s4_fx_reg, s4_fy_reg, s4_fz_reg;

    logic [23:0] mag_x, mag_y, mag_z;
    assign mag_x = s0_px_reg[23] ? 24'(-s0_px_reg) : s0_px_reg;
    assign mag_y = s0_py_reg[23] ? 24'(-s0_py_reg) : s0_py_reg;
    assign mag_z = s0_pz_reg[23] ? 24'(-s0_pz_reg) : s0_pz_reg;

    logic [48:0] d2_next;
    axis_t       ax_next, ay_next, az_next;
    assign d2_next = 49'(s1_sqx_reg) + 49'(s1_sqy_reg) + 49'(s1_sqz_reg);
    assign ax_next = split_axis(s1_scx_reg, 9'(GRID_XY));
    assign ay_next = split_axis(s1_scy_reg, 9'(GRID_XY));
    assign az_next = split_axis(s1_scz_reg, 9'(GRID_Z));

    logic out_next;
    assign out_next = d2_next > {1'b0, radius_sq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_ctl_reg   <= '0;
            s4_ctl_reg   <= '0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_ctl_reg.valid   <= s2_valid_reg && s2_op_reg;
            s3_ctl_reg.outside <= s2_out_reg;
            s3_ctl_reg.clipped <= s2_clip_reg && !s2_out_reg;
            s3_ctl_reg.zero_re <= s2_out_reg;
            s3_ctl_reg.zero_im <= s2_out_reg || !s2_cplx_reg;
            s4_ctl_reg         <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_op_reg    <= op;
        s0_slot_reg  <= box_slot;
        s0_col_reg   <= load_col;
        s0_row_reg   <= load_row;
        s0_layer_reg <= load_layer;
        s0_word_reg  <= {load_im, load_re};
        s0_px_reg    <= pos_x;
        s0_py_reg    <= pos_y;
        s0_pz_reg    <= pos_z;

        s1_op_reg    <= s0_op_reg;
        s1_slot_reg  <= s0_slot_reg;
        s1_col_reg   <= s0_col_reg;
        s1_row_reg   <= s0_row_reg;
        s1_layer_reg <= s0_layer_reg;
        s1_word_reg  <= s0_word_reg;
        s1_sqx_reg   <= 48'(s0_px_reg * s0_px_reg);
        s1_sqy_reg   <= 48'(s0_py_reg * s0_py_reg);
        s1_sqz_reg   <= 48'(s0_pz_reg * s0_pz_reg);
        s1_scx_reg   <= 48'(mag_x) * 48'(inv_x_reg);
        s1_scy_reg   <= 48'(mag_y) * 48'(inv_y_reg);
        s1_scz_reg   <= 48'(mag_z) * 48'(inv_z_reg);

        s2_op_reg    <= s1_op_reg;
        s2_slot_reg  <= s1_slot_reg;
        s2_col_reg   <= s1_col_reg;
        s2_row_reg   <= s1_row_reg;
        s2_layer_reg <= s1_layer_reg;
        s2_word_reg  <= s1_word_reg;
        s2_out_reg   <= out_next;
        s2_clip_reg  <= ax_next.clip || ay_next.clip || az_next.clip;
        s2_cplx_reg  <= cmask_reg[s1_slot_reg];
        s2_x0_reg    <= ax_next.i0[XB-1:0];
        s2_x1_reg    <= ax_next.i1[XB-1:0];
        s2_y0_reg    <= ay_next.i0[XB-1:0];
        s2_y1_reg    <= ay_next.i1[XB-1:0];
        s2_z0_reg    <= az_next.i0[ZB-1:0];
        s2_z1_reg    <= az_next.i1[ZB-1:0];
        s2_fx_reg    <= ax_next.frac;
        s2_fy_reg    <= ay_next.frac;
        s2_fz_reg    <= az_next.frac;

        s3_par_reg <= {s2_z1_reg[0], s2_z0_reg[0], s2_y1_reg[0], s2_y0_reg[0],
                       s2_x1_reg[0], s2_x0_reg[0]};
        s3_fx_reg  <= s2_fx_reg;
        s3_fy_reg  <= s2_fy_reg;
        s3_fz_reg  <= s2_fz_reg;

        s4_fx_reg  <= s3_fx_reg;
        s4_fy_reg  <= s3_fy_reg;
        s4_fz_reg  <= s3_fz_reg;
    end

    // bank b holds words whose x, y, z parities are b[0], b[1], b[2]
    logic [WORD_BITS-1:0] bank_rdata [BANKS];
    logic [BANK_AW-1:0]   bank_waddr;
    assign bank_waddr = {s2_slot_reg, s2_layer_reg[ZB-1:1], s2_row_reg[XB-1:1],
                         s2_col_reg[XB-1:1]};

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [XB-1:0]      xc, yc;
        logic [ZB-1:0]      zc;
        logic [BANK_AW-1:0] raddr;
        logic               we;
        assign xc = (s2_x0_reg[0] == 1'(b & 1))        ? s2_x0_reg : s2_x1_reg;
        assign yc = (s2_y0_reg[0] == 1'((b >> 1) & 1)) ? s2_y0_reg : s2_y1_reg;
        assign zc = (s2_z0_reg[0] == 1'((b >> 2) & 1)) ? s2_z0_reg : s2_z1_reg;
        assign raddr = {s2_slot_reg, zc[ZB-1:1], yc[XB-1:1], xc[XB-1:1]};
        assign we = s2_valid_reg && !s2_op_reg
                    && ({s2_layer_reg[0], s2_row_reg[0], s2_col_reg[0]} == 3'(b));

        tgl_ram #(
            .WIDTH (WORD_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (bank_waddr),
            .wdata (s2_word_reg),
            .raddr (raddr),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 8; c++)
        begin
            logic [2:0] bsel;
            bsel = {c[2] ? s3_par_reg[5] : s3_par_reg[4],
                    c[1] ? s3_par_reg[3] : s3_par_reg[2],
                    c[0] ? s3_par_reg[1] : s3_par_reg[0]};
            s4_corner_reg[0][c] <= bank_rdata[bsel][SAMPLE_BITS-1:0];
            s4_corner_reg[1][c] <= bank_rdata[bsel][WORD_BITS-1:SAMPLE_BITS];
        end
    end

    tgl_ctl_t tree_ctl;

    tgl_lerp_tree u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (s4_ctl_reg),
        .corner  (s4_corner_reg),
        .fx      (s4_fx_reg),
        .fy      (s4_fy_reg),
        .fz      (s4_fz_reg),
        .out_ctl (tree_ctl),
        .out_re  (value_re),
        .out_im  (value_im)
    );

    assign done    = tree_ctl.valid;
    assign outside = tree_ctl.outside;
    assign clipped = tree_ctl.clipped;
endmodule
`default_nettype wire

>>> design/tgl_checker.sv
`default_nettype none
module tgl_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               op,
    input wire logic               done,
    input wire logic signed [23:0] value_re,
    input wire logic signed [23:0] value_im,
    input wire logic               outside,
    input wire logic               clipped
);
    import tgl_pkg::*;

    a_query_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op |-> ##PIPE_LAT done)
        else $error("query transfer without result");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && op, PIPE_LAT))
        else $error("result without query transfer");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && outside |-> value_re == 24'sd0 && value_im == 24'sd0 && !clipped)
        else $error("outside result not zero");
endmodule

bind trilinear_grid_lookup tgl_checker u_tgl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .done     (done),
    .value_re (value_re),
    .value_im (value_im),
    .outside  (outside),
    .clipped  (clipped)
);
`default_nettype wire
